/* hdl/ffha_pkg.sv */
// Package for the first-fit heap allocator: field widths, codes, state encoding
// and the layout of one heap slot entry. No dependencies.
package ffha_pkg;

  localparam int HEAP_WORDS_DEF = 1024;

  localparam int OPCODE_W = 2;
  localparam int SIZE_W   = 11;
  localparam int TADDR_W  = 11;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 3;
  localparam int START_W  = 10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLAIM = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_BLOCK = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_ALLOC,
    S_FREE,
    S_CHECK,
    S_RESP
  } state_e;

  // One heap slot: set where a block begins, with the block length beside it.
  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } slot_t;

endpackage

/* hdl/ffha_in_if.sv */
// Request channel of the first-fit heap allocator: valid/ready plus the request.
// Depends on ffha_pkg for the field widths.
interface ffha_in_if import ffha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SIZE_W-1:0]   request_size;
  logic [TADDR_W-1:0]  target_address;

  modport source (output valid, opcode, request_size, target_address, input ready);
  modport sink   (input valid, opcode, request_size, target_address, output ready);
endinterface

/* hdl/ffha_out_if.sv */
// Response channel of the first-fit heap allocator: valid/ready plus the result.
// Depends on ffha_pkg for the field widths.
interface ffha_out_if import ffha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  block_start;

  modport source (output valid, status, block_start, input ready);
  modport sink   (input valid, status, block_start, output ready);
endinterface

/* hdl/first_fit_heap_allocator_core.sv */
// First-fit heap allocator: one slot memory, a scan sequencer and an output register.
// Depends on ffha_pkg, ffha_in_if and ffha_out_if.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | opcode, request_size, target_address
//  out_o   | out | valid / ready | status, block_start
//
// After reset the slot memory is cleared one slot a cycle with in_i.ready low.
// Allocate walks the heap from slot 0 one slot a cycle through the memory's single
// read port, a used block being jumped over whole. Check walks down from the
// address. One item is in work at a time; a finished result waits in the output
// register while the next beat is taken, and a full output register stalls only
// the result hand-over.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
  parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ffha_in_if.sink    in_i,
  ffha_out_if.source out_o
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int PW = ((AW > TADDR_W) ? AW : TADDR_W) + 1;
  localparam logic [PW-1:0] HEAP_P = PW'(HEAP_WORDS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HEAP_WORDS - 1);

  state_e state_q, state_d;

  opcode_e            op_q;
  logic [SIZE_W-1:0]  size_q;
  logic [TADDR_W-1:0] addr_q;

  logic [PW-1:0]      ip_q, ip_d;
  logic               ip_live_q, ip_live_d;
  logic               rd_vld_q, rd_vld_d;
  logic [PW-1:0]      rd_pos_q, rd_pos_d;
  logic [LEN_W-1:0]   run_len_q, run_len_d;
  logic [AW-1:0]      run_start_q, run_start_d;
  logic [AW-1:0]      clr_q, clr_d;

  status_e            res_status_q, res_status_d;
  logic [START_W-1:0] res_start_q, res_start_d;
  logic               out_vld_q, out_vld_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [START_W-1:0] out_start_q;

  // Slot memory ports.
  slot_t              mem_q [HEAP_WORDS];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  slot_t              mem_wdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  slot_t              rd_data_q;

  logic               in_acc;
  logic               slot_free;
  logic [PW-1:0]      addr_ext;
  logic [PW-1:0]      skip_tgt;
  logic [PW-1:0]      chk_end;
  logic [AW-1:0]      alloc_start;
  logic [LEN_W-1:0]   new_len;
  logic               issue;

  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_vld_q || out_o.ready;
  assign addr_ext  = PW'(addr_q);

  // A zero length is stepped over as a single slot.
  assign skip_tgt    = rd_pos_q + ((rd_data_q.len == '0) ? PW'(1) : PW'(rd_data_q.len));
  assign chk_end     = rd_pos_q + PW'(rd_data_q.len);
  assign alloc_start = (run_len_q == '0) ? rd_pos_q[AW-1:0] : run_start_q;
  assign new_len     = run_len_q + LEN_W'(1);

  always_comb begin
    state_d      = state_q;
    ip_d         = ip_q;
    ip_live_d    = ip_live_q;
    rd_vld_d     = 1'b0;
    rd_pos_d     = ip_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = '0;
    rd_en        = 1'b0;
    rd_addr      = ip_q[AW-1:0];
    issue        = 1'b0;
    in_i.ready   = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = S_START;
        end
      end

      S_START: begin
        res_start_d = '0;
        ip_live_d   = 1'b1;
        run_len_d   = '0;
        unique case (op_q)
          OP_CLAIM: begin
            ip_d = '0;
            if (size_q == '0) begin
              res_status_d = ST_BAD_SIZE;
              state_d      = S_RESP;
            end else begin
              state_d = S_ALLOC;
            end
          end
          OP_FREE, OP_CHECK: begin
            ip_d = addr_ext;
            if (addr_ext >= HEAP_P) begin
              res_status_d = ST_RANGE;
              state_d      = S_RESP;
            end else begin
              state_d = (op_q == OP_FREE) ? S_FREE : S_CHECK;
            end
          end
          OP_NOP: begin
            res_status_d = ST_OK;
            state_d      = S_RESP;
          end
          default: begin
            res_status_d = ST_OK;
            state_d      = S_RESP;
          end
        endcase
      end

      S_ALLOC: begin
        issue = 1'b1;
        if (rd_vld_q) begin
          if (rd_data_q.used) begin
            // Jump the whole used block and restart the free run after it.
            issue     = 1'b0;
            run_len_d = '0;
            if (skip_tgt >= HEAP_P) begin
              res_status_d = ST_NO_SPACE;
              state_d      = S_RESP;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = skip_tgt[AW-1:0];
              rd_pos_d = skip_tgt;
              rd_vld_d = 1'b1;
              ip_d     = skip_tgt + PW'(1);
            end
          end else if (new_len == size_q) begin
            issue        = 1'b0;
            mem_we       = 1'b1;
            mem_waddr    = alloc_start;
            mem_wdata    = '{used: 1'b1, len: size_q};
            res_status_d = ST_OK;
            res_start_d  = START_W'(alloc_start);
            state_d      = S_RESP;
          end else if (rd_pos_q == HEAP_P - PW'(1)) begin
            issue        = 1'b0;
            res_status_d = ST_NO_SPACE;
            state_d      = S_RESP;
          end else begin
            run_len_d   = new_len;
            run_start_d = alloc_start;
          end
        end
        if (issue && (ip_q < HEAP_P)) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          ip_d     = ip_q + PW'(1);
        end
      end

      S_FREE: begin
        if (rd_vld_q) begin
          if (rd_data_q.used && (rd_data_q.len != '0)) begin
            mem_we       = 1'b1;
            mem_waddr    = rd_pos_q[AW-1:0];
            res_status_d = ST_OK;
          end else begin
            res_status_d = ST_NOT_BLOCK;
          end
          state_d = S_RESP;
        end else begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
        end
      end

      S_CHECK: begin
        issue = 1'b1;
        if (rd_vld_q) begin
          if (rd_data_q.used) begin
            issue = 1'b0;
            if (chk_end > addr_ext) begin
              res_status_d = ST_OK;
              res_start_d  = START_W'(rd_pos_q);
            end else begin
              res_status_d = ST_NOT_BLOCK;
            end
            state_d = S_RESP;
          end else if (rd_pos_q == '0) begin
            issue        = 1'b0;
            res_status_d = ST_NOT_BLOCK;
            state_d      = S_RESP;
          end
        end
        if (issue && ip_live_q) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          ip_d      = ip_q - PW'(1);
          ip_live_d = (ip_q != '0);
        end
      end

      S_RESP: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_vld_d = ((state_q == S_RESP) && slot_free) || (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= opcode_e'(in_i.opcode);
      size_q <= in_i.request_size;
      addr_q <= in_i.target_address;
    end
    ip_q         <= ip_d;
    ip_live_q    <= ip_live_d;
    rd_pos_q     <= rd_pos_d;
    run_len_q    <= run_len_d;
    run_start_q  <= run_start_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    if ((state_q == S_RESP) && slot_free) begin
      out_status_q <= res_status_q;
      out_start_q  <= (res_status_q == ST_OK) ? res_start_q : '0;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_status_q;
  assign out_o.block_start = out_start_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_START))
    else $error("accepted beat did not start an operation");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_ALLOC || state_q == S_FREE || state_q == S_CHECK))
    else $error("slot read data pending outside a scan");

  a_write_is_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != S_CLEAR)) |=> (res_status_q == ST_OK))
    else $error("slot memory written by a failed operation");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for first_fit_heap_allocator_core: a directed table, then random
// allocate, free, check and no-op requests, each result compared against an in-bench heap
// model or pinned row. Depends on ffha_pkg, ffha_in_if, ffha_out_if and the core.
module tb_top;
  import ffha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_WORDS   = HEAP_WORDS_DEF;
  localparam int N_RANDOM     = 555;
  localparam int N_CALM_TAIL  = 60;
  localparam int CYCLE_LIMIT  = 2_500_000;
  localparam int N_DIRECTED   = 26;

  typedef struct packed {
    status_e            status;
    logic [START_W-1:0] start;
  } heap_result_t;

  typedef struct packed {
    opcode_e            op;
    logic [SIZE_W-1:0]  size;
    logic [TADDR_W-1:0] addr;
    logic               fixed;
    status_e            status;
    logic [START_W-1:0] start;
  } request_row_t;

  logic clk;
  logic rst_n;

  ffha_in_if  req_if ();
  ffha_out_if rsp_if ();

  first_fit_heap_allocator_core #(.HEAP_WORDS(HEAP_WORDS)) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Heap model: block start flags and the length held at each start.
  bit               start_flag [HEAP_WORDS];
  logic [LEN_W-1:0] blk_len    [HEAP_WORDS];

  heap_result_t awaited_results[$];
  heap_result_t pinned_result;
  logic         pinned;
  bit           idle_on;

  int n_errors;
  int n_requests;
  int n_results;
  int n_per_op [4];
  int n_per_status [8];
  longint cycles;

  // Rows with a pinned result can be read straight off the heap contents at that point.
  request_row_t directed_rows [N_DIRECTED] = '{
    '{OP_CHECK, 11'd0,    11'd0,    1'b1, ST_NOT_BLOCK, 10'd0},
    '{OP_FREE,  11'd0,    11'd0,    1'b1, ST_NOT_BLOCK, 10'd0},
    '{OP_CLAIM, 11'd0,    11'd2047, 1'b1, ST_BAD_SIZE,  10'd0},
    '{OP_CLAIM, 11'd1025, 11'd0,    1'b1, ST_NO_SPACE,  10'd0},
    '{OP_CLAIM, 11'd2047, 11'd0,    1'b1, ST_NO_SPACE,  10'd0},
    '{OP_FREE,  11'd0,    11'd1024, 1'b1, ST_RANGE,     10'd0},
    '{OP_CHECK, 11'd0,    11'd2047, 1'b1, ST_RANGE,     10'd0},
    '{OP_NOP,   11'd2047, 11'd2047, 1'b1, ST_OK,        10'd0},
    '{OP_CLAIM, 11'd1,    11'd0,    1'b1, ST_OK,        10'd0},
    '{OP_CLAIM, 11'd1,    11'd0,    1'b1, ST_OK,        10'd1},
    '{OP_CLAIM, 11'd3,    11'd0,    1'b1, ST_OK,        10'd2},
    '{OP_CHECK, 11'd0,    11'd3,    1'b0, ST_OK,        10'd0},
    '{OP_CHECK, 11'd0,    11'd5,    1'b0, ST_OK,        10'd0},
    '{OP_FREE,  11'd0,    11'd3,    1'b0, ST_OK,        10'd0},
    '{OP_FREE,  11'd0,    11'd1,    1'b1, ST_OK,        10'd0},
    '{OP_CLAIM, 11'd2,    11'd0,    1'b0, ST_OK,        10'd0},
    '{OP_CLAIM, 11'd1,    11'd0,    1'b0, ST_OK,        10'd0},
    '{OP_CHECK, 11'd0,    11'd1023, 1'b0, ST_OK,        10'd0},
    '{OP_CLAIM, 11'd1024, 11'd0,    1'b1, ST_NO_SPACE,  10'd0},
    '{OP_FREE,  11'd0,    11'd0,    1'b1, ST_OK,        10'd0},
    '{OP_FREE,  11'd0,    11'd1,    1'b1, ST_OK,        10'd0},
    '{OP_FREE,  11'd0,    11'd2,    1'b1, ST_OK,        10'd0},
    '{OP_FREE,  11'd0,    11'd5,    1'b1, ST_OK,        10'd0},
    '{OP_CLAIM, 11'd1024, 11'd0,    1'b1, ST_OK,        10'd0},
    '{OP_CHECK, 11'd0,    11'd1023, 1'b0, ST_OK,        10'd0},
    '{OP_FREE,  11'd0,    11'd0,    1'b1, ST_OK,        10'd0}
  };

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Applies one request to the heap model and returns the result the core should give.
  function automatic heap_result_t apply_heap_op(logic [OPCODE_W-1:0] op,
                                                 logic [SIZE_W-1:0] size,
                                                 logic [TADDR_W-1:0] addr);
    heap_result_t res;
    int pos;
    int run_start;
    int run_len;
    res.status = ST_OK;
    res.start  = '0;
    case (op)
      OP_CLAIM: begin
        if (size == '0) begin
          res.status = ST_BAD_SIZE;
        end else begin
          res.status = ST_NO_SPACE;
          pos = 0;
          while (pos < HEAP_WORDS) begin
            if (start_flag[pos]) begin
              // A used block is jumped over whole; a zero length only steps one slot.
              pos += (blk_len[pos] == '0) ? 1 : int'(blk_len[pos]);
            end else begin
              run_start = pos;
              run_len   = 0;
              while (pos < HEAP_WORDS && !start_flag[pos] && run_len < int'(size)) begin
                run_len++;
                pos++;
              end
              if (run_len >= int'(size)) begin
                start_flag[run_start] = 1'b1;
                blk_len[run_start]    = size;
                res.status = ST_OK;
                res.start  = run_start[START_W-1:0];
                break;
              end
            end
          end
        end
      end
      OP_FREE: begin
        if (int'(addr) >= HEAP_WORDS) begin
          res.status = ST_RANGE;
        end else if (!start_flag[addr] || blk_len[addr] == '0) begin
          res.status = ST_NOT_BLOCK;
        end else begin
          start_flag[addr] = 1'b0;
          blk_len[addr]    = '0;
        end
      end
      OP_CHECK: begin
        if (int'(addr) >= HEAP_WORDS) begin
          res.status = ST_RANGE;
        end else begin
          res.status = ST_NOT_BLOCK;
          for (int p = int'(addr); p >= 0; p--) begin
            if (start_flag[p]) begin
              if (p + int'(blk_len[p]) > int'(addr)) begin
                res.status = ST_OK;
                res.start  = p[START_W-1:0];
              end
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    n_errors++;
  endtask

  // Request beats feed the model; result beats are checked against the oldest expectation.
  always @(posedge clk) begin : watch
    heap_result_t want;
    if (req_if.valid && req_if.ready) begin
      want = apply_heap_op(req_if.opcode, req_if.request_size, req_if.target_address);
      if (pinned) want = pinned_result;
      awaited_results.push_back(want);
      n_requests++;
      n_per_op[req_if.opcode]++;
    end
    if (rsp_if.valid && rsp_if.ready) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result beat status=%0d start=%0d with nothing outstanding",
                                  rsp_if.status, rsp_if.block_start));
      end else begin
        want = awaited_results.pop_front();
        n_per_status[want.status]++;
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    n_results, rsp_if.status, want.status));
        if (rsp_if.block_start !== want.start)
          report_mismatch($sformatf("result %0d: block_start %0d, expected %0d",
                                    n_results, rsp_if.block_start, want.start));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, awaited_results.size());
      $display("** first_fit_heap_allocator_core: FAILED **");
      $finish;
    end
  end

  // Result side back-pressure, in bursts while idling is allowed.
  initial begin : result_stall
    int hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_if.ready = 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready = 1'b0;
        hold = $urandom_range(0, 5);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // Called just after a falling edge; leaves valid high until the beat is taken.
  task automatic send_request(opcode_e op, logic [SIZE_W-1:0] size,
                              logic [TADDR_W-1:0] addr, logic fix, heap_result_t fixed_res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_if.opcode         = op;
    req_if.request_size   = size;
    req_if.target_address = addr;
    pinned                = fix;
    pinned_result         = fixed_res;
    req_if.valid          = 1'b1;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Mostly well-formed traffic: allocations, frees of live blocks and checks near them, plus some noise.
  task automatic pick_random_request(output opcode_e op, output logic [SIZE_W-1:0] size,
                                     output logic [TADDR_W-1:0] addr);
    int starts[$];
    int pick;
    int roll;
    for (int s = 0; s < HEAP_WORDS; s++)
      if (start_flag[s]) starts.push_back(s);
    roll = $urandom_range(0, 99);
    size = SIZE_W'($urandom_range(0, 2047));
    addr = TADDR_W'($urandom_range(0, 2047));
    if (roll < 38) begin
      op   = OP_CLAIM;
      roll = $urandom_range(0, 99);
      if (roll < 70)      size = SIZE_W'($urandom_range(1, 32));
      else if (roll < 85) size = SIZE_W'($urandom_range(33, 200));
      else if (roll < 93) size = SIZE_W'($urandom_range(201, 1024));
      else if (roll < 96) size = '0;
      else                size = SIZE_W'($urandom_range(1025, 2047));
    end else if (roll < 72) begin
      op = OP_FREE;
      if (starts.size() != 0 && $urandom_range(0, 9) < 8) begin
        addr = TADDR_W'(starts[$urandom_range(0, starts.size() - 1)]);
      end else if ($urandom_range(0, 4) != 0) begin
        addr = TADDR_W'($urandom_range(0, HEAP_WORDS - 1));
      end
    end else if (roll < 95) begin
      op = OP_CHECK;
      if (starts.size() != 0 && $urandom_range(0, 9) < 7) begin
        pick = starts[$urandom_range(0, starts.size() - 1)];
        // Up to one slot past the end, so the boundary is hit from both sides.
        addr = TADDR_W'(pick + $urandom_range(0, int'(blk_len[pick])));
      end else if ($urandom_range(0, 4) != 0) begin
        addr = TADDR_W'($urandom_range(0, HEAP_WORDS - 1));
      end
    end else begin
      op = OP_NOP;
    end
  endtask

  initial begin : stimulus
    opcode_e            op;
    logic [SIZE_W-1:0]  size;
    logic [TADDR_W-1:0] addr;
    heap_result_t       fixed_res;
    req_if.valid          = 1'b0;
    req_if.opcode         = OP_CLAIM;
    req_if.request_size   = '0;
    req_if.target_address = '0;
    pinned                = 1'b0;
    pinned_result         = '0;
    idle_on               = 1'b1;
    rst_n                 = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      @(negedge clk);
      fixed_res.status = directed_rows[i].status;
      fixed_res.start  = directed_rows[i].start;
      send_request(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
                   directed_rows[i].fixed, fixed_res);
    end

    fixed_res = '0;
    for (int i = 0; i < N_RANDOM; i++) begin
      @(negedge clk);
      if (i >= N_RANDOM - N_CALM_TAIL) idle_on = 1'b0;
      else if (i % 40 == 0)            idle_on = ($urandom_range(0, 3) != 0);
      pick_random_request(op, size, addr);
      send_request(op, size, addr, 1'b0, fixed_res);
    end

    @(negedge clk);
    req_if.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests: %0d allocate, %0d free, %0d check, %0d no-op; %0d results.",
             n_requests, n_per_op[OP_CLAIM], n_per_op[OP_FREE], n_per_op[OP_CHECK],
             n_per_op[OP_NOP], n_results);
    $display("Outcomes: %0d ok, %0d bad size, %0d no space, %0d out of range, %0d not a block.",
             n_per_status[ST_OK], n_per_status[ST_BAD_SIZE], n_per_status[ST_NO_SPACE],
             n_per_status[ST_RANGE], n_per_status[ST_NOT_BLOCK]);
    if (n_errors == 0) begin
      $display("** first_fit_heap_allocator_core: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
